// File: rtl/core/motor_calibration_sequencer_assert.svh
// assertion macros for the motor calibration sequencer
// no dependencies; included inside the modules that check themselves
`ifndef MOTOR_CALIBRATION_SEQUENCER_ASSERT_SVH
`define MOTOR_CALIBRATION_SEQUENCER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define MCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define MCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mcs_pkg.sv
// types and constants of the motor calibration sequencer
// no dependencies; used by the channel interfaces and every module
`default_nettype none

package mcs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // consecutive centred samples that end centering
    localparam logic [3:0] CENTERED_RUN = 4'd10;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CENTER = 3'd1,
        PH_PRE    = 3'd2,
        PH_DRIVE  = 3'd3,
        PH_POST   = 3'd4,
        PH_ABORT  = 3'd5
    } t_phase;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN        = 3'd0,
        CFG_BIAS_DRIVE  = 3'd1,
        CFG_CENTER_TOL  = 3'd2,
        CFG_UPPER_LIMIT = 3'd3,
        CFG_LOWER_LIMIT = 3'd4,
        CFG_SETTLE      = 3'd5,
        CFG_TRY_LIMIT   = 3'd6,
        CFG_SAMPLE_RATE = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0]        gain;
        logic [14:0]        bias_drive;
        logic [14:0]        center_tolerance;
        logic [14:0]        upper_limit;
        logic signed [15:0] lower_limit;
        logic [15:0]        settle_ticks;
        logic [15:0]        center_try_limit;
        logic [15:0]        sample_rate;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain:             12'd768,
        bias_drive:       15'd256,
        center_tolerance: 15'd82,
        upper_limit:      15'd32767,
        lower_limit:      16'h8000,
        settle_ticks:     16'd250,
        center_try_limit: 16'd666,
        sample_rate:      16'd333
    };

endpackage

`default_nettype wire

// File: rtl/core/mcs_in_if.sv
// input sample channel: valid, ready and one sample word
// depends on mcs_pkg
`default_nettype none

interface mcs_in_if import mcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] angle;
    logic signed [15:0] drive_request;
    logic               drive_done;

    modport source (output valid, output opcode, output angle, output drive_request,
                    output drive_done, input ready);
    modport sink   (input valid, input opcode, input angle, input drive_request,
                    input drive_done, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mcs_out_if.sv
// result channel: valid, ready and one result word
// depends on mcs_pkg
`default_nettype none

interface mcs_out_if import mcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_voltage;
    logic signed [15:0] angle_echo;
    logic signed [31:0] angular_velocity;
    logic [2:0]         phase;
    logic [23:0]        tick_index;
    logic               report_valid;
    logic               run_done;

    modport source (output valid, output drive_voltage, output angle_echo,
                    output angular_velocity, output phase, output tick_index,
                    output report_valid, output run_done, input ready);
    modport sink   (input valid, input drive_voltage, input angle_echo,
                    input angular_velocity, input phase, input tick_index,
                    input report_valid, input run_done, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mcs_cfg_if.sv
// register write channel: valid, ready, register index and write data
// depends on mcs_pkg
`default_nettype none

interface mcs_cfg_if import mcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/motor_calibration_sequencer.sv
// motor calibration sequencer top level: sample register, run sequencer, result register
// depends on mcs_pkg, the channel interfaces, mcs_arith and the assertion macros
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------------
//   i_in     | in  | opcode, angle, drive_request, drive_done
//   o_out    | out | drive_voltage, angle_echo, angular_velocity, phase, ...
//   i_cfg    | in  | register index and write data, always ready
//
// one word in and one result out per cycle while the result side is ready; an accepted
// word passes the sample register, then the result register
// the run state updates in the cycle a word leaves the sample register
// a stalled result holds both registers; input ready follows the result register
// synchronous reset returns registers to defaults and the run to idle
`default_nettype none
`include "motor_calibration_sequencer_assert.svh"

module motor_calibration_sequencer import mcs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mcs_in_if.sink     i_in,
    mcs_out_if.source  o_out,
    mcs_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;

    // sample register
    logic               r_s1_valid;
    t_opcode            r_s1_opcode;
    logic signed [15:0] r_s1_angle;
    logic signed [15:0] r_s1_req;
    logic               r_s1_done;

    // run state
    t_phase             r_phase,    n_phase;
    logic [3:0]         r_in_range, n_in_range;
    logic [15:0]        r_try,      n_try;
    logic [15:0]        r_settle,   n_settle;
    logic [23:0]        r_tick,     n_tick;
    logic signed [15:0] r_prev,     n_prev;

    // result register
    logic               r_o_valid;
    logic signed [15:0] r_o_drive,  n_o_drive;
    logic signed [15:0] r_o_echo,   n_o_echo;
    logic signed [31:0] r_o_vel,    n_o_vel;
    t_phase             r_o_phase,  n_o_phase;
    logic [23:0]        r_o_tix,    n_o_tix;
    logic               r_o_report, n_o_report;
    logic               r_o_done,   n_o_done;

    logic               w_adv;
    logic               w_fire;
    logic [16:0]        w_angle_x;
    logic [16:0]        w_mag;
    logic               w_centered;
    logic               w_out_of_range;
    logic [16:0]        w_settle_inc;
    logic               w_settle_zero;
    logic signed [15:0] w_center_drive;
    logic signed [31:0] w_velocity;

    assign w_adv      = !r_o_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_fire     = r_s1_valid && w_adv;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_GAIN:        r_cfg.gain             <= i_cfg.data[11:0];
                CFG_BIAS_DRIVE:  r_cfg.bias_drive       <= i_cfg.data[14:0];
                CFG_CENTER_TOL:  r_cfg.center_tolerance <= i_cfg.data[14:0];
                CFG_UPPER_LIMIT: r_cfg.upper_limit      <= i_cfg.data[14:0];
                CFG_LOWER_LIMIT: r_cfg.lower_limit      <= i_cfg.data;
                CFG_SETTLE:      r_cfg.settle_ticks     <= i_cfg.data;
                CFG_TRY_LIMIT:   r_cfg.center_try_limit <= i_cfg.data;
                CFG_SAMPLE_RATE: r_cfg.sample_rate      <= i_cfg.data;
            endcase
        end
    end

    // sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_opcode <= t_opcode'(i_in.opcode);
            r_s1_angle  <= i_in.angle;
            r_s1_req    <= i_in.drive_request;
            r_s1_done   <= i_in.drive_done;
        end
    end

    mcs_arith u_arith (
        .i_angle        (r_s1_angle),
        .i_prev_angle   (r_prev),
        .i_cfg          (r_cfg),
        .o_center_drive (w_center_drive),
        .o_velocity     (w_velocity)
    );

    // |angle| needs 17 bits for the most negative sample
    assign w_angle_x      = {r_s1_angle[15], r_s1_angle};
    assign w_mag          = w_angle_x[16] ? (~w_angle_x + 17'd1) : w_angle_x;
    assign w_centered     = w_mag < {2'b00, r_cfg.center_tolerance};
    assign w_out_of_range = (w_mag > {2'b00, r_cfg.upper_limit}) ||
                            (r_s1_angle < $signed(r_cfg.lower_limit));
    assign w_settle_inc   = {1'b0, r_settle} + 17'd1;
    assign w_settle_zero  = (r_cfg.settle_ticks == 16'd0);

    // next run state
    always_comb begin
        n_phase    = r_phase;
        n_in_range = r_in_range;
        n_try      = r_try;
        n_settle   = r_settle;
        n_tick     = r_tick;
        n_prev     = r_prev;
        if (w_fire) begin
            if (r_s1_opcode == OP_START) begin
                n_phase    = PH_CENTER;
                n_in_range = 4'd0;
                n_try      = 16'd0;
                n_settle   = 16'd0;
                n_tick     = 24'd0;
            end else begin
                unique case (r_phase)
                    PH_CENTER: begin
                        n_prev = r_s1_angle;
                        if (w_centered) begin
                            n_in_range = (r_in_range == 4'hF) ? r_in_range
                                                              : r_in_range + 4'd1;
                        end else begin
                            n_in_range = 4'd0;
                        end
                        n_try = (r_try == 16'hFFFF) ? r_try : r_try + 16'd1;
                        // a try limit of zero ends after the first tick
                        if ((n_in_range >= CENTERED_RUN) || (n_try >= r_cfg.center_try_limit)) begin
                            n_settle = 16'd0;
                            n_phase  = w_settle_zero ? PH_DRIVE : PH_PRE;
                        end
                    end
                    PH_PRE, PH_DRIVE, PH_POST: begin
                        if (w_out_of_range) begin
                            n_phase = PH_ABORT;
                        end else begin
                            n_prev = r_s1_angle;
                            n_tick = (r_tick == 24'hFF_FFFF) ? r_tick : r_tick + 24'd1;
                            if (r_phase == PH_DRIVE) begin
                                if (r_s1_done) begin
                                    n_settle = 16'd0;
                                    n_phase  = w_settle_zero ? PH_IDLE : PH_POST;
                                end
                            end else begin
                                n_settle = w_settle_inc[15:0];
                                if (w_settle_inc >= {1'b0, r_cfg.settle_ticks}) begin
                                    n_settle = 16'd0;
                                    n_phase  = (r_phase == PH_PRE) ? PH_DRIVE : PH_IDLE;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result word
    always_comb begin
        n_o_drive  = 16'sd0;
        n_o_echo   = r_s1_angle;
        n_o_vel    = 32'sd0;
        n_o_phase  = r_phase;
        n_o_tix    = 24'd0;
        n_o_report = 1'b0;
        n_o_done   = 1'b0;
        if (r_s1_opcode == OP_START) begin
            n_o_echo  = 16'sd0;
            n_o_phase = PH_CENTER;
        end else begin
            unique case (r_phase)
                PH_CENTER: begin
                    n_o_drive = w_center_drive;
                    n_o_vel   = w_velocity;
                end
                PH_PRE, PH_DRIVE, PH_POST: begin
                    if (w_out_of_range) begin
                        n_o_phase = PH_ABORT;
                        n_o_done  = 1'b1;
                    end else begin
                        n_o_vel    = w_velocity;
                        n_o_tix    = r_tick;
                        n_o_report = 1'b1;
                        n_o_drive  = (r_phase == PH_DRIVE) ? r_s1_req : 16'sd0;
                        n_o_done   = (n_phase == PH_IDLE);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_in_range <= 4'd0;
            r_try      <= 16'd0;
            r_settle   <= 16'd0;
            r_tick     <= 24'd0;
            r_prev     <= 16'sd0;
        end else begin
            r_phase    <= n_phase;
            r_in_range <= n_in_range;
            r_try      <= n_try;
            r_settle   <= n_settle;
            r_tick     <= n_tick;
            r_prev     <= n_prev;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_drive  <= n_o_drive;
            r_o_echo   <= n_o_echo;
            r_o_vel    <= n_o_vel;
            r_o_phase  <= n_o_phase;
            r_o_tix    <= n_o_tix;
            r_o_report <= n_o_report;
            r_o_done   <= n_o_done;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.drive_voltage    = r_o_drive;
    assign o_out.angle_echo       = r_o_echo;
    assign o_out.angular_velocity = r_o_vel;
    assign o_out.phase            = r_o_phase;
    assign o_out.tick_index       = r_o_tix;
    assign o_out.report_valid     = r_o_report;
    assign o_out.run_done         = r_o_done;

    // centering leaves as soon as the run count is reached
    `MCS_ASSERT_SAME(a_in_range_bound, i_clk, i_rst_n, 1'b1, r_in_range <= CENTERED_RUN, "centred run count overran")
    `MCS_ASSERT_NEXT(a_start_centers, i_clk, i_rst_n, w_fire && (r_s1_opcode == OP_START), r_phase == PH_CENTER, "start did not enter centering")
    `MCS_ASSERT_SAME(a_report_phase, i_clk, i_rst_n, r_o_valid && r_o_report, (r_o_phase == PH_PRE) || (r_o_phase == PH_DRIVE) || (r_o_phase == PH_POST), "report outside a reported phase")
    `MCS_ASSERT_SAME(a_abort_quiet, i_clk, i_rst_n, r_o_valid && r_o_done && !r_o_report, (r_o_phase == PH_ABORT) && (r_o_drive == 16'sd0) && (r_o_vel == 32'sd0), "abort word not quiet")

endmodule

`default_nettype wire

// File: rtl/core/mcs_arith.sv
// centering drive and angular velocity arithmetic, purely combinational
// depends on mcs_pkg
`default_nettype none

module mcs_arith import mcs_pkg::*; (
    input  wire logic signed [15:0] i_angle,
    input  wire logic signed [15:0] i_prev_angle,
    input  wire t_cfg               i_cfg,
    output logic signed [15:0]      o_center_drive,
    output logic signed [31:0]      o_velocity
);

    logic signed [28:0] w_prod;
    logic signed [28:0] w_p;
    logic signed [16:0] w_q;
    logic signed [17:0] w_bias;
    logic signed [17:0] w_drv;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_vprod;

    // -kp * angle rounded half up, Q4.8 * Q3.12 -> Q7.8
    assign w_prod = $signed({1'b0, i_cfg.gain}) * i_angle;
    assign w_p    = 29'sd2048 - w_prod;
    assign w_q    = w_p[28:12];
    assign w_bias = $signed({3'b000, i_cfg.bias_drive});

    // bias pushes toward zero
    assign w_drv = (i_angle > 16'sd0) ? ($signed({w_q[16], w_q}) - w_bias)
                                      : ($signed({w_q[16], w_q}) + w_bias);

    always_comb begin
        if (w_drv > 18'sd32767) begin
            o_center_drive = 16'sh7FFF;
        end else if (w_drv < -18'sd32768) begin
            o_center_drive = 16'sh8000;
        end else begin
            o_center_drive = w_drv[15:0];
        end
    end

    assign w_diff  = $signed({i_angle[15], i_angle}) - $signed({i_prev_angle[15], i_prev_angle});
    assign w_vprod = w_diff * $signed({1'b0, i_cfg.sample_rate});

    always_comb begin
        if (w_vprod > 34'sh0_7FFF_FFFF) begin
            o_velocity = 32'sh7FFF_FFFF;
        end else if (w_vprod < -34'sh0_8000_0000) begin
            o_velocity = 32'sh8000_0000;
        end else begin
            o_velocity = w_vprod[31:0];
        end
    end

endmodule

`default_nettype wire

// File: tb/calib_tb_pkg.sv
// result tracker for the motor calibration sequencer bench: run-state prediction and checking
// depends on mcs_pkg for phases, opcodes, register indexes and reset values
`timescale 1ns / 1ps

package calib_tb_pkg;
    import mcs_pkg::*;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [15:0] echo;
        logic signed [31:0] velocity;
        logic [2:0]         phase;
        logic [23:0]        tick;
        logic               report;
        logic               last;
    } calib_report_t;

    class calib_tracker;
        // register copies
        int gain, bias, tol, upper, lower_lim, settle, try_limit, rate;
        // run state
        t_phase phase;
        int centred_run, tries, settle_cnt, ticks, prev_angle;

        calib_report_t pending_reports[$];
        int unsigned errors;
        int unsigned shown;

        function new();
            gain       = CFG_RESET.gain;
            bias       = CFG_RESET.bias_drive;
            tol        = CFG_RESET.center_tolerance;
            upper      = CFG_RESET.upper_limit;
            lower_lim  = $signed(CFG_RESET.lower_limit);
            settle     = CFG_RESET.settle_ticks;
            try_limit  = CFG_RESET.center_try_limit;
            rate       = CFG_RESET.sample_rate;
            phase      = PH_IDLE;
            centred_run = 0;
            tries      = 0;
            settle_cnt = 0;
            ticks      = 0;
            prev_angle = 0;
            errors     = 0;
            shown      = 0;
        endfunction

        function void apply_reg_write(t_cfg_idx idx, logic [15:0] data);
            case (idx)
                CFG_GAIN:        gain = data[11:0];
                CFG_BIAS_DRIVE:  bias = data[14:0];
                CFG_CENTER_TOL:  tol = data[14:0];
                CFG_UPPER_LIMIT: upper = data[14:0];
                CFG_LOWER_LIMIT: lower_lim = $signed(data);
                CFG_SETTLE:      settle = data;
                CFG_TRY_LIMIT:   try_limit = data;
                CFG_SAMPLE_RATE: rate = data;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function logic signed [31:0] next_velocity(int a);
            longint v;
            v = longint'(a - prev_angle) * longint'(rate);
            prev_angle = a;
            return 32'(clamp(v, -64'sd2147483648, 64'sd2147483647));
        endfunction

        // -kp*angle rounded half up, then bias toward zero
        function logic signed [15:0] centring_drive(int a);
            longint p;
            longint q;
            p = -longint'(gain) * longint'(a) + 2048;
            q = p >>> 12;
            q += (a > 0) ? -longint'(bias) : longint'(bias);
            return 16'(clamp(q, -32768, 32767));
        endfunction

        function void accept_sample(logic op, logic signed [15:0] ang,
                                    logic signed [15:0] req, logic done);
            calib_report_t r;
            int a;
            int mag;
            a   = ang;
            mag = (a < 0) ? -a : a;
            r.drive    = '0;
            r.echo     = ang;
            r.velocity = '0;
            r.phase    = phase;
            r.tick     = '0;
            r.report   = 1'b0;
            r.last     = 1'b0;
            if (op == OP_START) begin
                phase = PH_CENTER;
                r.phase = PH_CENTER;
                r.echo = '0;
                centred_run = 0;
                tries = 0;
                settle_cnt = 0;
                ticks = 0;
            end else if (phase == PH_CENTER) begin
                r.velocity = next_velocity(a);
                r.drive = centring_drive(a);
                if (mag < tol) begin
                    if (centred_run < 15) centred_run++;
                end else begin
                    centred_run = 0;
                end
                if (tries < 65535) tries++;
                if (centred_run >= int'(CENTERED_RUN) || tries >= try_limit) begin
                    settle_cnt = 0;
                    phase = (settle == 0) ? PH_DRIVE : PH_PRE;
                end
            end else if (phase == PH_PRE || phase == PH_DRIVE || phase == PH_POST) begin
                if (mag > upper || a < lower_lim) begin
                    phase = PH_ABORT;
                    r.phase = PH_ABORT;
                    r.last = 1'b1;
                end else begin
                    r.velocity = next_velocity(a);
                    r.report = 1'b1;
                    r.tick = 24'(ticks);
                    if (ticks < 24'hFFFFFF) ticks++;
                    if (phase == PH_DRIVE) begin
                        r.drive = req;
                        if (done) begin
                            settle_cnt = 0;
                            if (settle == 0) begin
                                phase = PH_IDLE;
                                r.last = 1'b1;
                            end else begin
                                phase = PH_POST;
                            end
                        end
                    end else begin
                        settle_cnt++;
                        if (settle_cnt >= settle) begin
                            settle_cnt = 0;
                            if (phase == PH_PRE) begin
                                phase = PH_DRIVE;
                            end else begin
                                phase = PH_IDLE;
                                r.last = 1'b1;
                            end
                        end
                    end
                end
            end
            pending_reports.push_back(r);
        endfunction

        function void check_report(calib_report_t got);
            calib_report_t want;
            if (pending_reports.size() == 0) begin
                errors++;
                if (shown < 10)
                    $display("%0t: unexpected result, phase %0d drive %0d", $time,
                             got.phase, got.drive);
                shown++;
                return;
            end
            want = pending_reports.pop_front();
            if (got.drive !== want.drive || got.echo !== want.echo ||
                got.velocity !== want.velocity || got.phase !== want.phase ||
                got.tick !== want.tick || got.report !== want.report ||
                got.last !== want.last) begin
                errors++;
                if (shown < 10)
                    $display({"%0t: mismatch (exp/act) drive %0d/%0d echo %0d/%0d",
                              " vel %0d/%0d phase %0d/%0d tick %0d/%0d rv %0b/%0b done %0b/%0b"},
                             $time, want.drive, got.drive, want.echo, got.echo,
                             want.velocity, got.velocity, want.phase, got.phase,
                             want.tick, got.tick, want.report, got.report,
                             want.last, got.last);
                shown++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb.sv
// top-level bench for motor_calibration_sequencer: drives samples and register writes,
// stalls the result side at random; depends on mcs_pkg, the channel interfaces and calib_tb_pkg
`timescale 1ns / 1ps

module tb;
    import mcs_pkg::*;
    import calib_tb_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   cycle_count;
    int   items_sent;

    calib_tracker tracker;

    mcs_in_if  in_ch ();
    mcs_out_if out_ch ();
    mcs_cfg_if cfg_ch ();

    motor_calibration_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // edges of the window now and then, otherwise uniform inside it
    function automatic int pick_between(int lo, int hi);
        int unsigned r;
        if (lo > hi) return rand16();
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // result side stalls
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
            end
        end
    end

    always @(posedge i_clk) begin
        calib_report_t got;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.drive    = out_ch.drive_voltage;
            got.echo     = out_ch.angle_echo;
            got.velocity = out_ch.angular_velocity;
            got.phase    = out_ch.phase;
            got.tick     = out_ch.tick_index;
            got.report   = out_ch.report_valid;
            got.last     = out_ch.run_done;
            tracker.check_report(got);
        end
    end

    task automatic send_item(t_opcode op, int ang, int req, bit done);
        int unsigned gap;
        gap = steady ? 0 : idle_cycles();
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.angle         <= 16'(ang);
        in_ch.drive_request <= 16'(req);
        in_ch.drive_done    <= done;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.accept_sample(in_ch.opcode, in_ch.angle, in_ch.drive_request,
                              in_ch.drive_done);
        items_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= 16'(value);
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        tracker.apply_reg_write(idx, cfg_ch.data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_calibration_regs();
        int unsigned r;
        r = $urandom_range(0, 9);
        write_reg(CFG_GAIN, r == 0 ? 0 : (r == 1 ? 4095 : $urandom_range(4095)));
        r = $urandom_range(0, 9);
        write_reg(CFG_BIAS_DRIVE, r == 0 ? 0 : (r == 1 ? 32767 :
                  (r < 6 ? $urandom_range(1023) : $urandom_range(32767))));
        r = $urandom_range(0, 9);
        write_reg(CFG_CENTER_TOL, r == 0 ? 0 : (r == 1 ? 32767 : $urandom_range(1, 4000)));
        r = $urandom_range(0, 9);
        write_reg(CFG_UPPER_LIMIT, r == 0 ? 0 : (r == 1 ? 32767 :
                  (r < 4 ? $urandom_range(32767) : $urandom_range(8000, 32767))));
        r = $urandom_range(0, 9);
        write_reg(CFG_LOWER_LIMIT, r == 0 ? -32768 : (r == 1 ? 32767 :
                  (r == 2 ? 0 : -int'($urandom_range(1000, 32768)))));
        // mostly short settle phases, the longest only rarely
        r = $urandom_range(0, 19);
        write_reg(CFG_SETTLE, r < 4 ? 0 : (r < 16 ? $urandom_range(1, 5) :
                  (r < 19 ? $urandom_range(6, 40) : 65535)));
        r = $urandom_range(0, 9);
        write_reg(CFG_TRY_LIMIT, r == 0 ? 0 : (r == 1 ? 1 :
                  (r == 2 ? 65535 : $urandom_range(1, 40))));
        r = $urandom_range(0, 9);
        write_reg(CFG_SAMPLE_RATE, r == 0 ? 1 : (r == 1 ? 65535 : $urandom_range(1, 65535)));
    endtask

    // next word follows the predicted run phase so that most runs get deep
    task automatic run_phase(int target);
        int counted;
        t_phase ph;
        t_opcode op;
        int ang, req;
        bit done;
        counted = 0;
        while (counted < target) begin
            ph   = tracker.phase;
            op   = OP_TICK;
            ang  = rand16();
            req  = rand16();
            done = $urandom_range(0, 1);
            if ($urandom_range(0, 49) == 0) begin
                op = OP_START;
            end else begin
                case (ph)
                    PH_IDLE, PH_ABORT: begin
                        if ($urandom_range(0, 3) != 0) op = OP_START;
                    end
                    PH_CENTER: begin
                        if (tracker.tol > 0 && $urandom_range(0, 9) < 8)
                            ang = pick_between(1 - tracker.tol, tracker.tol - 1);
                    end
                    default: begin
                        if ($urandom_range(0, 24) != 0)
                            ang = pick_between(tracker.lower_lim > -tracker.upper ?
                                               tracker.lower_lim : -tracker.upper,
                                               tracker.upper);
                        if (ph == PH_DRIVE) done = ($urandom_range(0, 5) == 0);
                    end
                endcase
            end
            send_item(op, ang, req, done);
            if (op == OP_START || (ph != PH_IDLE && ph != PH_ABORT)) counted++;
        end
    endtask

    initial begin
        tracker = new();
        steady = 1'b0;
        cycle_count = 0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_TICK;
        in_ch.angle <= '0;
        in_ch.drive_request <= '0;
        in_ch.drive_done <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_GAIN;
        cfg_ch.data <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks, extremes while centring, tolerance edges, restart mid-run
        send_item(OP_TICK, 32767, 32767, 1'b1);
        send_item(OP_TICK, -32768, -32768, 1'b0);
        send_item(OP_START, 123, 5, 1'b1);
        send_item(OP_TICK, 32767, 0, 1'b0);
        send_item(OP_TICK, -32768, 0, 1'b0);
        send_item(OP_TICK, 0, 0, 1'b0);
        send_item(OP_TICK, 81, 0, 1'b0);
        send_item(OP_TICK, -81, 0, 1'b0);
        send_item(OP_TICK, 82, 0, 1'b0);
        send_item(OP_TICK, -82, 0, 1'b0);
        send_item(OP_TICK, 1, 0, 1'b0);
        send_item(OP_TICK, -1, 0, 1'b0);
        send_item(OP_START, 0, 0, 1'b0);
        wait_drained();

        // saturating gain and bias, no settle, one centring try, tight limits
        write_reg(CFG_GAIN, 4095);
        write_reg(CFG_BIAS_DRIVE, 32767);
        write_reg(CFG_CENTER_TOL, 100);
        write_reg(CFG_UPPER_LIMIT, 1000);
        write_reg(CFG_LOWER_LIMIT, -500);
        write_reg(CFG_SETTLE, 0);
        write_reg(CFG_TRY_LIMIT, 1);
        write_reg(CFG_SAMPLE_RATE, 65535);
        send_item(OP_START, 0, 0, 1'b0);
        send_item(OP_TICK, -32768, 0, 1'b0);
        send_item(OP_TICK, 1000, 32767, 1'b0);
        send_item(OP_TICK, -500, -32768, 1'b1);
        send_item(OP_START, 0, 0, 1'b0);
        send_item(OP_TICK, 0, 0, 1'b0);
        send_item(OP_TICK, 1001, 100, 1'b0);
        send_item(OP_TICK, 5, 100, 1'b1);
        send_item(OP_START, 0, 0, 1'b0);
        send_item(OP_TICK, 0, 0, 1'b0);
        send_item(OP_TICK, -501, 0, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            wait_drained();
            load_calibration_regs();
            steady = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(60, 120));
        end

        wait_drained();
        tracker.errors += tracker.pending_reports.size();
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mcs_pkg.sv
rtl/core/mcs_in_if.sv
rtl/core/mcs_out_if.sv
rtl/core/mcs_cfg_if.sv
rtl/core/mcs_arith.sv
rtl/core/motor_calibration_sequencer.sv
tb/calib_tb_pkg.sv
tb/tb.sv
